FILE: rtl/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and constants for the dirty region tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;

  localparam int KIND_W      = 3;
  localparam int FIELD_W     = 16;
  localparam int OFFSET_W    = 10;
  localparam int COORD_OUT_W = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int OP_CODE_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_RECT     = 3'd0,
    KIND_POINT    = 3'd1,
    KIND_MARK_ALL = 3'd2,
    KIND_CLEAR    = 3'd3,
    KIND_FLUSH    = 3'd4
  } kind_t;

  typedef enum logic [OP_CODE_W-1:0] {
    OP_NOP      = 3'd0,
    OP_MERGE    = 3'd1,
    OP_MARK_ALL = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_FLUSH    = 3'd4
  } op_code_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_OFFSET = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_OFFSET    = 1'd1;

endpackage

`default_nettype wire

FILE: rtl/drt_if.sv
// ----------------------------------------------------------------------------
// drt_if
// Valid/ready channels for tracker items and flush results.
// ----------------------------------------------------------------------------
`default_nettype none

interface drt_in_if;
  logic                               valid;
  logic                               ready;
  logic        [drt_pkg::KIND_W-1:0]  kind;
  logic signed [drt_pkg::FIELD_W-1:0] pos_x;
  logic signed [drt_pkg::FIELD_W-1:0] pos_y;
  logic signed [drt_pkg::FIELD_W-1:0] rect_width;
  logic signed [drt_pkg::FIELD_W-1:0] rect_height;

  modport source(output valid, kind, pos_x, pos_y, rect_width, rect_height, input ready);
  modport sink(input valid, kind, pos_x, pos_y, rect_width, rect_height, output ready);
endinterface

interface drt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 window_valid;
  logic [drt_pkg::COORD_OUT_W-1:0]      col_first;
  logic [drt_pkg::COORD_OUT_W-1:0]      col_last;
  logic [drt_pkg::COORD_OUT_W-1:0]      row_first;
  logic [drt_pkg::COORD_OUT_W-1:0]      row_last;

  modport source(output valid, window_valid, col_first, col_last, row_first, row_last,
                 input ready);
  modport sink(input valid, window_valid, col_first, col_last, row_first, row_last,
               output ready);
endinterface

`default_nettype wire

FILE: rtl/dirty_region_tracker.sv
// ----------------------------------------------------------------------------
// dirty_region_tracker
// Bounding box of changed frame-buffer area; flush emits the panel window.
//
//   channel     dir  handshake            payload
//   item_in     in   valid/ready          kind, pos_x, pos_y, rect_width,
//                                         rect_height
//   result_out  out  valid/ready          window_valid, col_first, col_last,
//                                         row_first, row_last
//   cfg         in   cfg_we (no ready)    cfg_index, cfg_data
//
// One item per cycle while result_out is ready; one result per item, in order.
// An accepted item is written to the operation queue and is then taken into
// the output register once that is free; its result is offered from there.
// Synchronous reset empties the box, zeroes offsets and drains the queue.
// A stalled output holds the back; the two-entry queue then fills and
// item_in.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_region_tracker #(
  parameter int SCREEN_WIDTH  = drt_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = drt_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [drt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [drt_pkg::OFFSET_W-1:0]    cfg_data,
  drt_in_if.sink                               item_in,
  drt_out_if.source                            result_out
);

  localparam int XW   = $clog2(SCREEN_WIDTH + 1);
  localparam int YW   = $clog2(SCREEN_HEIGHT + 1);
  localparam int OP_W = drt_pkg::OP_CODE_W + 2 * XW + 2 * YW;

  logic [OP_W-1:0] front_op;
  logic [OP_W-1:0] queue_op;
  logic            queue_full;
  logic            queue_valid;
  logic            back_ready;

  assign item_in.ready = !queue_full;

  drt_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .kind       (item_in.kind),
    .pos_x      (item_in.pos_x),
    .pos_y      (item_in.pos_y),
    .rect_width (item_in.rect_width),
    .rect_height(item_in.rect_height),
    .op_data    (front_op)
  );

  drt_queue #(
    .WIDTH(OP_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (item_in.valid && !queue_full),
    .push_data(front_op),
    .full     (queue_full),
    .pop      (queue_valid && back_ready),
    .not_empty(queue_valid),
    .pop_data (queue_op)
  );

  drt_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op_valid    (queue_valid),
    .op_ready    (back_ready),
    .op_data     (queue_op),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .window_valid(result_out.window_valid),
    .col_first   (result_out.col_first),
    .col_last    (result_out.col_last),
    .row_first   (result_out.row_first),
    .row_last    (result_out.row_last)
  );

endmodule

`default_nettype wire

FILE: rtl/drt_front.sv
// ----------------------------------------------------------------------------
// drt_front
// Classifies an item: clips rectangles and points to the screen and turns
// each item into one box operation.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_front #(
  parameter int  SCREEN_WIDTH  = drt_pkg::SCREEN_WIDTH_DEF,
  parameter int  SCREEN_HEIGHT = drt_pkg::SCREEN_HEIGHT_DEF,
  localparam int XW            = $clog2(SCREEN_WIDTH + 1),
  localparam int YW            = $clog2(SCREEN_HEIGHT + 1),
  localparam int OP_W          = drt_pkg::OP_CODE_W + 2 * XW + 2 * YW
) (
  input  wire logic        [drt_pkg::KIND_W-1:0]  kind,
  input  wire logic signed [drt_pkg::FIELD_W-1:0] pos_x,
  input  wire logic signed [drt_pkg::FIELD_W-1:0] pos_y,
  input  wire logic signed [drt_pkg::FIELD_W-1:0] rect_width,
  input  wire logic signed [drt_pkg::FIELD_W-1:0] rect_height,
  output logic             [OP_W-1:0]             op_data
);

  localparam int SW_BITS = drt_pkg::FIELD_W + 2;

  typedef struct packed {
    drt_pkg::op_code_t op;
    logic [XW-1:0]     x0;
    logic [XW-1:0]     x1;
    logic [YW-1:0]     y0;
    logic [YW-1:0]     y1;
  } op_t;

  localparam logic signed [SW_BITS-1:0] SW_S = SW_BITS'(SCREEN_WIDTH);
  localparam logic signed [SW_BITS-1:0] SH_S = SW_BITS'(SCREEN_HEIGHT);
  localparam logic signed [SW_BITS-1:0] ONE  = SW_BITS'(1);

  logic signed [SW_BITS-1:0] xs, xe, x0c, x1c;
  logic signed [SW_BITS-1:0] ys, ye, y0c, y1c;
  op_t                       op;

  always_comb begin
    xs  = SW_BITS'(pos_x);
    ys  = SW_BITS'(pos_y);
    xe  = xs + SW_BITS'(rect_width);
    ye  = ys + SW_BITS'(rect_height);
    x0c = xs[SW_BITS-1] ? '0 : xs;
    y0c = ys[SW_BITS-1] ? '0 : ys;
    x1c = (xe > SW_S) ? SW_S : xe;
    y1c = (ye > SH_S) ? SH_S : ye;

    op    = '0;
    op.op = drt_pkg::OP_NOP;
    case (drt_pkg::kind_t'(kind))
      drt_pkg::KIND_RECT: begin
        if ((x1c > x0c) && (y1c > y0c)) begin
          op.op = drt_pkg::OP_MERGE;
          op.x0 = XW'(x0c);
          op.x1 = XW'(x1c);
          op.y0 = YW'(y0c);
          op.y1 = YW'(y1c);
        end
      end
      drt_pkg::KIND_POINT: begin
        if (!xs[SW_BITS-1] && (xs < SW_S) && !ys[SW_BITS-1] && (ys < SH_S)) begin
          op.op = drt_pkg::OP_MERGE;
          op.x0 = XW'(xs);
          op.x1 = XW'(xs + ONE);
          op.y0 = YW'(ys);
          op.y1 = YW'(ys + ONE);
        end
      end
      drt_pkg::KIND_MARK_ALL: op.op = drt_pkg::OP_MARK_ALL;
      drt_pkg::KIND_CLEAR:    op.op = drt_pkg::OP_CLEAR;
      drt_pkg::KIND_FLUSH:    op.op = drt_pkg::OP_FLUSH;
      default:                op.op = drt_pkg::OP_NOP;
    endcase
  end

  assign op_data = op;

endmodule

`default_nettype wire

FILE: rtl/drt_queue.sv
// ----------------------------------------------------------------------------
// drt_queue
// Two-entry queue of box operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic      [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/drt_back.sv
// ----------------------------------------------------------------------------
// drt_back
// Holds the dirty box and offsets, applies operations and registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_back #(
  parameter int  SCREEN_WIDTH  = drt_pkg::SCREEN_WIDTH_DEF,
  parameter int  SCREEN_HEIGHT = drt_pkg::SCREEN_HEIGHT_DEF,
  localparam int XW            = $clog2(SCREEN_WIDTH + 1),
  localparam int YW            = $clog2(SCREEN_HEIGHT + 1),
  localparam int OP_W          = drt_pkg::OP_CODE_W + 2 * XW + 2 * YW
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [drt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [drt_pkg::OFFSET_W-1:0]        cfg_data,
  input  wire logic                                op_valid,
  output logic                                     op_ready,
  input  wire logic [OP_W-1:0]                     op_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     window_valid,
  output logic      [drt_pkg::COORD_OUT_W-1:0]     col_first,
  output logic      [drt_pkg::COORD_OUT_W-1:0]     col_last,
  output logic      [drt_pkg::COORD_OUT_W-1:0]     row_first,
  output logic      [drt_pkg::COORD_OUT_W-1:0]     row_last
);

  localparam int CW = drt_pkg::COORD_OUT_W;

  typedef struct packed {
    drt_pkg::op_code_t op;
    logic [XW-1:0]     x0;
    logic [XW-1:0]     x1;
    logic [YW-1:0]     y0;
    logic [YW-1:0]     y1;
  } op_t;

  localparam logic [XW-1:0] BOX_W = XW'(SCREEN_WIDTH);
  localparam logic [YW-1:0] BOX_H = YW'(SCREEN_HEIGHT);

  op_t                           op;
  logic                          take;
  logic                          box_live;
  logic                          flush_hit;
  logic [XW-1:0]                 box_left;
  logic [XW-1:0]                 box_right;
  logic [YW-1:0]                 box_top;
  logic [YW-1:0]                 box_bottom;
  logic [drt_pkg::OFFSET_W-1:0]  column_offset;
  logic [drt_pkg::OFFSET_W-1:0]  row_offset;

  assign op        = op_t'(op_data);
  assign op_ready  = !out_valid || out_ready;
  assign take      = op_valid && op_ready;
  assign box_live  = (box_left < box_right) && (box_top < box_bottom);
  assign flush_hit = (op.op == drt_pkg::OP_FLUSH) && box_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left      <= BOX_W;
      box_right     <= '0;
      box_top       <= BOX_H;
      box_bottom    <= '0;
      column_offset <= '0;
      row_offset    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          drt_pkg::CFG_COLUMN_OFFSET: column_offset <= cfg_data;
          drt_pkg::CFG_ROW_OFFSET:    row_offset    <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        out_valid <= 1'b1;
        case (op.op)
          drt_pkg::OP_MERGE: begin
            if (op.x0 < box_left) box_left <= op.x0;
            if (op.x1 > box_right) box_right <= op.x1;
            if (op.y0 < box_top) box_top <= op.y0;
            if (op.y1 > box_bottom) box_bottom <= op.y1;
          end
          drt_pkg::OP_MARK_ALL: begin
            box_left   <= '0;
            box_right  <= BOX_W;
            box_top    <= '0;
            box_bottom <= BOX_H;
          end
          drt_pkg::OP_CLEAR: begin
            box_left   <= BOX_W;
            box_right  <= '0;
            box_top    <= BOX_H;
            box_bottom <= '0;
          end
          drt_pkg::OP_FLUSH: begin
            if (box_live) begin
              box_left   <= BOX_W;
              box_right  <= '0;
              box_top    <= BOX_H;
              box_bottom <= '0;
            end
          end
          default: ;
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      window_valid <= flush_hit;
      if (flush_hit) begin
        col_first <= CW'(box_left) + CW'(column_offset);
        col_last  <= CW'(box_right) - CW'(1) + CW'(column_offset);
        row_first <= CW'(box_top) + CW'(row_offset);
        row_last  <= CW'(box_bottom) - CW'(1) + CW'(row_offset);
      end else begin
        col_first <= '0;
        col_last  <= '0;
        row_first <= '0;
        row_last  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/drt_checker.sv
// ----------------------------------------------------------------------------
// drt_checker
// Port-level checks on the dirty region tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic                               window_valid,
  input wire logic [drt_pkg::COORD_OUT_W-1:0]    col_first,
  input wire logic [drt_pkg::COORD_OUT_W-1:0]    col_last,
  input wire logic [drt_pkg::COORD_OUT_W-1:0]    row_first,
  input wire logic [drt_pkg::COORD_OUT_W-1:0]    row_last
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_valid) && $stable(col_first)
      && $stable(col_last) && $stable(row_first) && $stable(row_last))
    else $error("stalled result changed");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_valid |-> col_first == '0 && col_last == '0
      && row_first == '0 && row_last == '0)
    else $error("non-window result carries coordinates");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_valid |-> col_first <= col_last && row_first <= row_last)
    else $error("window edges out of order");

endmodule

bind dirty_region_tracker drt_checker u_drt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .window_valid(result_out.window_valid),
  .col_first   (result_out.col_first),
  .col_last    (result_out.col_last),
  .row_first   (result_out.row_first),
  .row_last    (result_out.row_last)
);

`default_nettype wire

FILE: tb/sv/dirty_region_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dirty_region_tracker_tb
// Self-checking bench for the dirty region tracker.
//
// Walks a short table of directed items: empty and full-screen flushes,
// clipping at every edge, off-screen points and an unused kind. Then it runs
// random phases under several column and row offset settings. Every accepted
// item goes through a local box tracker. Each result is compared field by
// field with the oldest pending window. The sender idles in random bursts.
// The receiver stalls on its own random pattern, with one long hold-off that
// fills the block and stalls its input.
// ----------------------------------------------------------------------------

module dirty_region_tracker_tb;

  localparam int KIND_W      = drt_pkg::KIND_W;
  localparam int FIELD_W     = drt_pkg::FIELD_W;
  localparam int OFFSET_W    = drt_pkg::OFFSET_W;
  localparam int COORD_OUT_W = drt_pkg::COORD_OUT_W;
  localparam int CFG_INDEX_W = drt_pkg::CFG_INDEX_W;

  localparam int SCR_W           = drt_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H           = drt_pkg::SCREEN_HEIGHT_DEF;
  localparam int OFFSET_MAX      = (1 << OFFSET_W) - 1;
  localparam int N_DIRECTED      = 26;
  localparam int N_PHASES        = 9;
  localparam int PHASE_ITEMS     = 220;
  localparam int LONG_HOLD       = 80;
  localparam int SETTLE_CYCLES   = 4;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  localparam logic signed [FIELD_W-1:0] Z    = 16'sd0;
  localparam logic signed [FIELD_W-1:0] MX   = 16'sh7fff;
  localparam logic signed [FIELD_W-1:0] MN   = 16'sh8000;
  localparam logic signed [FIELD_W-1:0] ONES = 16'shffff;
  localparam logic [COORD_OUT_W-1:0]    U0   = 16'd0;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] rect_width;
    logic signed [FIELD_W-1:0] rect_height;
  } tracker_item_t;

  typedef struct packed {
    logic                   window_valid;
    logic [COORD_OUT_W-1:0] col_first;
    logic [COORD_OUT_W-1:0] col_last;
    logic [COORD_OUT_W-1:0] row_first;
    logic [COORD_OUT_W-1:0] row_last;
  } window_t;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [FIELD_W-1:0]     x;
    logic [FIELD_W-1:0]     y;
    logic [FIELD_W-1:0]     w;
    logic [FIELD_W-1:0]     h;
    logic                   known;
    logic                   valid;
    logic [COORD_OUT_W-1:0] cf;
    logic [COORD_OUT_W-1:0] cl;
    logic [COORD_OUT_W-1:0] rf;
    logic [COORD_OUT_W-1:0] rl;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{drt_pkg::KIND_FLUSH,    Z, Z, Z, Z, 1'b1, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_MARK_ALL, Z, Z, Z, Z, 1'b1, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_FLUSH,    Z, Z, Z, Z, 1'b1, 1'b1, U0, 16'd319, U0, 16'd239},
    '{drt_pkg::KIND_RECT,     MN, MN, MX, MX, 1'b1, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_RECT,     -16'sd10, -16'sd10, 16'sd20, 16'sd20, 1'b0, 1'b0,
      U0, U0, U0, U0},
    '{drt_pkg::KIND_RECT,     16'sd300, 16'sd230, MX, MX, 1'b0, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_FLUSH,    Z, Z, Z, Z, 1'b1, 1'b1, U0, 16'd319, U0, 16'd239},
    '{drt_pkg::KIND_RECT,     MX, Z, MX, 16'sd1, 1'b0, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_RECT,     16'sd10, 16'sd10, Z, 16'sd5, 1'b0, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_RECT,     16'sd10, 16'sd10, 16'sd5, MN, 1'b0, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_FLUSH,    Z, Z, Z, Z, 1'b1, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_POINT,    Z, Z, Z, Z, 1'b0, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_POINT,    16'sd319, 16'sd239, Z, Z, 1'b0, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_FLUSH,    Z, Z, Z, Z, 1'b1, 1'b1, U0, 16'd319, U0, 16'd239},
    '{drt_pkg::KIND_POINT,    16'sd320, Z, Z, Z, 1'b0, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_POINT,    -16'sd1, 16'sd5, Z, Z, 1'b0, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_POINT,    MN, MX, Z, Z, 1'b0, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_FLUSH,    Z, Z, Z, Z, 1'b1, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_POINT,    16'sd7, 16'sd9, Z, Z, 1'b0, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_CLEAR,    Z, Z, Z, Z, 1'b1, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_FLUSH,    Z, Z, Z, Z, 1'b1, 1'b0, U0, U0, U0, U0},
    '{KIND_SPARE_5,           ONES, ONES, ONES, ONES, 1'b1, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_POINT,    16'sd100, 16'sd50, Z, Z, 1'b0, 1'b0, U0, U0, U0, U0},
    '{drt_pkg::KIND_FLUSH,    Z, Z, Z, Z, 1'b1, 1'b1, 16'd100, 16'd100,
      16'd50, 16'd50},
    '{drt_pkg::KIND_RECT,     16'sd40, 16'sd20, 16'sd60, 16'sd30, 1'b0, 1'b0,
      U0, U0, U0, U0},
    '{drt_pkg::KIND_FLUSH,    Z, Z, Z, Z, 1'b0, 1'b0, U0, U0, U0, U0}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [OFFSET_W-1:0]    cfg_data;

  drt_in_if  in_if();
  drt_out_if out_if();

  dirty_region_tracker u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_in    (in_if.sink),
    .result_out (out_if.source)
  );

  always #5 clk = ~clk;

  // local copy of the tracker state and offsets
  int              box_l, box_r, box_t, box_b;
  logic [OFFSET_W-1:0] col_off, row_off;
  window_t         window_q[$];

  int unsigned n_items, n_results, n_windows, n_empty_flush, n_settings;
  int unsigned n_in_stalls, mismatches, stuck_cycles;
  bit          hold_req, hold_active;

  function automatic void empty_box();
    box_l = SCR_W;
    box_r = 0;
    box_t = SCR_H;
    box_b = 0;
  endfunction

  function automatic void grow_box(input int x0, input int x1, input int y0, input int y1);
    if (x0 < box_l) box_l = x0;
    if (x1 > box_r) box_r = x1;
    if (y0 < box_t) box_t = y0;
    if (y1 > box_b) box_b = y1;
  endfunction

  function automatic window_t predict_window(input tracker_item_t it);
    window_t w;
    int      x, y, cw, ch;
    w  = '0;
    x  = it.pos_x;
    y  = it.pos_y;
    cw = it.rect_width;
    ch = it.rect_height;
    case (it.kind)
      drt_pkg::KIND_RECT: begin
        if (x < 0) begin
          cw += x;
          x = 0;
        end
        if (x + cw > SCR_W) cw = SCR_W - x;
        if (y < 0) begin
          ch += y;
          y = 0;
        end
        if (y + ch > SCR_H) ch = SCR_H - y;
        if (cw > 0 && ch > 0) grow_box(x, x + cw, y, y + ch);
      end
      drt_pkg::KIND_POINT: begin
        if (x >= 0 && x < SCR_W && y >= 0 && y < SCR_H) grow_box(x, x + 1, y, y + 1);
      end
      drt_pkg::KIND_MARK_ALL: begin
        box_l = 0;
        box_r = SCR_W;
        box_t = 0;
        box_b = SCR_H;
      end
      drt_pkg::KIND_CLEAR: empty_box();
      drt_pkg::KIND_FLUSH: begin
        if (box_l < box_r && box_t < box_b) begin
          w.window_valid = 1'b1;
          w.col_first    = COORD_OUT_W'(box_l + int'(col_off));
          w.col_last     = COORD_OUT_W'(box_r - 1 + int'(col_off));
          w.row_first    = COORD_OUT_W'(box_t + int'(row_off));
          w.row_last     = COORD_OUT_W'(box_b - 1 + int'(row_off));
          empty_box();
        end else begin
          n_empty_flush++;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_coord(input int span);
    int v;
    if ($urandom_range(0, 9) < 8) v = int'($urandom_range(0, span + 60)) - 30;
    else v = int'($urandom);
    return FIELD_W'(v);
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_size(input int span);
    int unsigned pick;
    int          v;
    pick = $urandom_range(0, 19);
    if (pick < 12) v = int'($urandom_range(1, span / 3));
    else if (pick < 15) v = int'($urandom_range(0, span + 40));
    else if (pick < 17) v = -int'($urandom_range(0, 40));
    else v = int'($urandom);
    return FIELD_W'(v);
  endfunction

  function automatic tracker_item_t random_item();
    tracker_item_t it;
    int unsigned   pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) it.kind = drt_pkg::KIND_RECT;
    else if (pick < 60) it.kind = drt_pkg::KIND_POINT;
    else if (pick < 64) it.kind = drt_pkg::KIND_MARK_ALL;
    else if (pick < 68) it.kind = drt_pkg::KIND_CLEAR;
    else if (pick < 95) it.kind = drt_pkg::KIND_FLUSH;
    else it.kind = KIND_SPARE_5 + KIND_W'($urandom_range(0, KIND_SPARE_7 - KIND_SPARE_5));
    it.pos_x       = rand_coord(SCR_W);
    it.pos_y       = rand_coord(SCR_H);
    it.rect_width  = rand_size(SCR_W);
    it.rect_height = rand_size(SCR_H);
    return it;
  endfunction

  task automatic send_item(input tracker_item_t it, input bit known, input window_t typed_want);
    window_t predicted;
    in_if.valid       <= 1'b1;
    in_if.kind        <= it.kind;
    in_if.pos_x       <= it.pos_x;
    in_if.pos_y       <= it.pos_y;
    in_if.rect_width  <= it.rect_width;
    in_if.rect_height <= it.rect_height;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predicted = predict_window(it);
    window_q.push_back(known ? typed_want : predicted);
    n_items++;
  endtask

  task automatic pause_sender();
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait until every pending window is back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offsets(input int unsigned col, input int unsigned row);
    cfg_we    <= 1'b1;
    cfg_index <= drt_pkg::CFG_COLUMN_OFFSET;
    cfg_data  <= OFFSET_W'(col);
    @(posedge clk);
    col_off    = OFFSET_W'(col);
    cfg_index <= drt_pkg::CFG_ROW_OFFSET;
    cfg_data  <= OFFSET_W'(row);
    @(posedge clk);
    row_off = OFFSET_W'(row);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned left, burst;
    left = count;
    while (left != 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_item(random_item(), 1'b0, '0);
      left -= burst;
      pause_sender();
    end
  endtask

  initial begin : stimulus
    directed_row_t row;
    tracker_item_t it;
    window_t       want;
    int unsigned   col, rw;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= drt_pkg::CFG_COLUMN_OFFSET;
    cfg_data          <= '0;
    in_if.valid       <= 1'b0;
    in_if.kind        <= drt_pkg::KIND_RECT;
    in_if.pos_x       <= '0;
    in_if.pos_y       <= '0;
    in_if.rect_width  <= '0;
    in_if.rect_height <= '0;
    empty_box();
    col_off = '0;
    row_off = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row  = DIRECTED_ROWS[i];
      it   = '{row.kind, row.x, row.y, row.w, row.h};
      want = '{row.valid, row.cf, row.cl, row.rf, row.rl};
      send_item(it, row.known, want);
      pause_sender();
    end
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin col = OFFSET_MAX; rw = OFFSET_MAX; end
        1: begin col = 0;          rw = 0;          end
        2: begin col = OFFSET_MAX; rw = 0;          end
        3: begin col = 0;          rw = OFFSET_MAX; end
        default: begin
          col = $urandom_range(0, OFFSET_MAX);
          rw  = $urandom_range(0, OFFSET_MAX);
        end
      endcase
      write_offsets(col, rw);
      if (p == 1) begin
        // keep offering items while the output is held off
        hold_req = 1'b1;
        wait (hold_active);
        while (hold_active) send_item(random_item(), 1'b0, '0);
      end
      run_random(PHASE_ITEMS);
      settle();
    end

    $display("run covered %0d items, %0d windows, %0d empty flushes, %0d offset settings",
             n_items, n_windows, n_empty_flush, n_settings);
    $display("output held off for %0d cycles once; input stalled %0d cycles in all",
             LONG_HOLD, n_in_stalls);
    if (mismatches == 0) begin
      $display("dirty_region_tracker test passed");
    end else begin
      $display("dirty_region_tracker test failed");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned pick, stall_len, run_len;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      run_len = 1;
      if (hold_req) begin
        hold_req     = 1'b0;
        hold_active  = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
        run_len     = 8;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          stall_len = 0;
          run_len   = $urandom_range(20, 60);
        end else if (pick < 8) begin
          stall_len = $urandom_range(1, 3);
          run_len   = $urandom_range(1, 6);
        end else begin
          stall_len = $urandom_range(4, 12);
          run_len   = $urandom_range(1, 3);
        end
        if (stall_len != 0) begin
          out_if.ready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
    end
  end

  task automatic report_mismatch(input string what, input window_t want, input window_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s at result %0d: expected v=%0d cols %0d..%0d rows %0d..%0d", what,
               n_results, want.window_valid, want.col_first, want.col_last,
               want.row_first, want.row_last);
      $display("  got v=%0d cols %0d..%0d rows %0d..%0d", got.window_valid,
               got.col_first, got.col_last, got.row_first, got.row_last);
    end
  endtask

  always @(posedge clk) begin
    window_t got, want;
    if (!rst && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.window_valid, out_if.col_first, out_if.col_last,
              out_if.row_first, out_if.row_last};
      if (window_q.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got);
      end else begin
        want = window_q.pop_front();
        if (got.window_valid !== want.window_valid || got.col_first !== want.col_first ||
            got.col_last !== want.col_last || got.row_first !== want.row_first ||
            got.row_last !== want.row_last) begin
          report_mismatch("window mismatch", want, got);
        end
        if (want.window_valid) n_windows++;
      end
      n_results++;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_if.valid === 1'b1 && in_if.ready !== 1'b1) n_in_stalls++;
    if (rst || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_CYCLES) begin
      $display("no progress for %0d cycles", stuck_cycles);
      $display("dirty_region_tracker test failed");
      $finish;
    end
  end

endmodule
